[hw/rtl/wvr_pkg.sv]
// Package for the wavetable voice: command codes, phase format and
// the sequencer state type. Used by the interfaces and the top level.
package wvr_pkg;

  localparam int FRACT_BITS  = 8;
  localparam int PHASE_W     = 16;
  localparam int TABLE_AW    = 8;
  localparam int SAMPLE_W    = 16;
  localparam int LEVEL_W     = 8;
  localparam int RAMP_W      = 16;
  localparam int FUNC_W      = 3;

  localparam logic [FUNC_W-1:0] FUNC_TICK      = 3'd0;
  localparam logic [FUNC_W-1:0] FUNC_SET_STEP  = 3'd1;
  localparam logic [FUNC_W-1:0] FUNC_SET_LEVEL = 3'd2;
  localparam logic [FUNC_W-1:0] FUNC_TERMINATE = 3'd3;
  localparam logic [FUNC_W-1:0] FUNC_WRITE     = 3'd4;
  localparam logic [FUNC_W-1:0] FUNC_RESET     = 3'd5;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_SCALE,
    ST_RCHK,
    ST_RMUL,
    ST_RDIV,
    ST_RFIN,
    ST_DONE
  } state_t;

endpackage

[hw/rtl/wvr_in_if.sv]
// Command channel of the wavetable voice: valid, ready and the command fields.
// Depends on wvr_pkg for the field widths.
interface wvr_in_if;
  import wvr_pkg::*;

  logic                       valid;
  logic                       ready;
  logic [FUNC_W-1:0]          func;
  logic [15:0]                target;
  logic [RAMP_W-1:0]          ramp_frames;
  logic [TABLE_AW-1:0]        wave_index;
  logic signed [SAMPLE_W-1:0] wave_sample;

  modport source (output valid, func, target, ramp_frames, wave_index, wave_sample,
                  input ready);
  modport sink   (input valid, func, target, ramp_frames, wave_index, wave_sample,
                  output ready);
endinterface

[hw/rtl/wvr_out_if.sv]
// Result channel of the wavetable voice: valid, ready, sample and finished flag.
// Depends on wvr_pkg for the sample width.
interface wvr_out_if;
  import wvr_pkg::*;

  logic                       valid;
  logic                       ready;
  logic signed [SAMPLE_W-1:0] sample;
  logic                       finished;

  modport source (output valid, sample, finished, input ready);
  modport sink   (input valid, sample, finished, output ready);
endinterface

[hw/rtl/wavetable_voice_with_ramps.sv]
// Top level of the wavetable voice: command decode, wave table, bit-serial
// level scaling and the shared bit-serial ramp multiply and divide.
// Depends on wvr_pkg, wvr_in_if and wvr_out_if.

// Every command other than a tick is taken without the voice leaving its idle
// state. A tick to an inactive voice goes straight to the done state. A tick to
// an active voice reads the wave table and runs the 8-step serial level multiply,
// then, for each of the step and level ramps that is moving, the 16-step serial
// multiply followed by the 16-step restoring divide, which both ramps share in
// turn. The result sits in an output register, so commands are taken while it
// waits to be collected.
module wavetable_voice_with_ramps (
  input  logic      clk,
  input  logic      rst,
  wvr_in_if.sink    cmd,
  wvr_out_if.source res
);
  import wvr_pkg::*;

  state_t state, state_next;

  logic signed [SAMPLE_W-1:0] wave_table [2**TABLE_AW];
  logic signed [SAMPLE_W-1:0] rd_data;

  logic [PHASE_W-1:0] phase;
  logic [15:0]        step_now, step_start, step_end, step_pos, step_len;
  logic [LEVEL_W-1:0] gain_now, gain_start, gain_end;
  logic [RAMP_W-1:0]  gain_pos, gain_len;
  logic               ending, active;

  logic [3:0]  cnt;
  logic        sel;
  logic [16:0] hi;
  logic [15:0] lo;

  logic signed [16:0]        sc_hi;
  logic [LEVEL_W-1:0]        sc_lo;
  logic signed [SAMPLE_W-1:0] sc_m;

  logic                       out_valid;
  logic signed [SAMPLE_W-1:0] out_sample;
  logic                       out_finished;

  logic                cmd_acc;
  logic                is_tick;
  logic                out_free;
  logic [TABLE_AW-1:0] rd_idx;
  logic [LEVEL_W-1:0]  gain_tgt;

  logic [15:0] cur_start, cur_end, cur_pos, cur_len, pos_n;
  logic        ramp_on, ramp_end, need_unit;
  logic [16:0] diff;
  logic        neg;
  logic [15:0] mag;
  logic [16:0] mul_sum;
  logic [16:0] div_t;
  logic        div_ge;
  logic [15:0] ramp_res;
  logic signed [16:0] sc_sum;

  assign cmd_acc  = cmd.valid && cmd.ready;
  assign is_tick  = cmd.func == FUNC_TICK;
  assign out_free = !out_valid || res.ready;
  assign rd_idx   = TABLE_AW'(phase >> FRACT_BITS);
  assign gain_tgt = (cmd.func == FUNC_TERMINATE) ? '0 : cmd.target[LEVEL_W-1:0];

  assign cur_start = sel ? {8'd0, gain_start} : step_start;
  assign cur_end   = sel ? {8'd0, gain_end}   : step_end;
  assign cur_pos   = sel ? gain_pos : step_pos;
  assign cur_len   = sel ? gain_len : step_len;
  assign pos_n     = cur_pos + 16'd1;
  assign ramp_on   = cur_len != 16'd0;
  assign ramp_end  = pos_n >= cur_len;
  assign need_unit = ramp_on && !ramp_end;

  assign diff     = {1'b0, cur_end} - {1'b0, cur_start};
  assign neg      = diff[16];
  assign mag      = neg ? 16'(-diff) : diff[15:0];
  assign mul_sum  = hi + {1'b0, (lo[0] ? mag : 16'd0)};
  assign div_t    = {hi[15:0], lo[15]};
  assign div_ge   = div_t >= {1'b0, cur_len};
  assign ramp_res = neg ? cur_start - lo : cur_start + lo;
  assign sc_sum   = sc_hi + (sc_lo[0] ? {sc_m[SAMPLE_W-1], sc_m} : 17'sd0);

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:  if (cmd_acc && is_tick) state_next = active ? ST_READ : ST_DONE;
      ST_READ:  state_next = ST_SCALE;
      ST_SCALE: if (cnt == 4'd7) state_next = ST_RCHK;
      ST_RCHK: begin
        if (need_unit) state_next = ST_RMUL;
        else if (sel) state_next = ST_DONE;
      end
      ST_RMUL:  if (cnt == 4'd15) state_next = ST_RDIV;
      ST_RDIV:  if (cnt == 4'd15) state_next = ST_RFIN;
      ST_RFIN:  state_next = sel ? ST_DONE : ST_RCHK;
      ST_DONE:  if (out_free) state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd.ready = state == ST_IDLE;
  end

  assign res.valid    = out_valid;
  assign res.sample   = out_sample;
  assign res.finished = out_finished;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      cnt   <= 4'd0;
      sel   <= 1'b0;
    end else begin
      state <= state_next;
      cnt   <= (state_next != state) ? 4'd0 : cnt + 4'd1;
      if (state == ST_SCALE) begin
        sel <= 1'b0;
      end else if ((state == ST_RCHK && !need_unit) || state == ST_RFIN) begin
        sel <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_acc && cmd.func == FUNC_WRITE) begin
      wave_table[cmd.wave_index] <= cmd.wave_sample;
    end
    if (cmd_acc && is_tick) begin
      rd_data <= wave_table[rd_idx];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= '0;
      step_now   <= '0;
      step_start <= '0;
      step_end   <= '0;
      step_pos   <= '0;
      step_len   <= '0;
      gain_now   <= '0;
      gain_start <= '0;
      gain_end   <= '0;
      gain_pos   <= '0;
      gain_len   <= '0;
      ending     <= 1'b0;
      active     <= 1'b0;
    end else begin
      if (cmd_acc) begin
        unique case (cmd.func)
          FUNC_TICK: begin
            if (active) phase <= phase + step_now;
          end
          FUNC_SET_STEP: begin
            step_start <= step_now;
            step_end   <= cmd.target;
            step_pos   <= '0;
            if (cmd.ramp_frames != '0 && step_now != cmd.target) begin
              step_len <= cmd.ramp_frames;
            end else begin
              step_now <= cmd.target;
              step_len <= '0;
            end
          end
          FUNC_SET_LEVEL, FUNC_TERMINATE: begin
            gain_start <= gain_now;
            gain_end   <= gain_tgt;
            gain_pos   <= '0;
            if (cmd.ramp_frames != '0 && gain_now != gain_tgt) begin
              gain_len <= cmd.ramp_frames;
            end else begin
              gain_now <= gain_tgt;
              gain_len <= '0;
            end
            if (cmd.func == FUNC_TERMINATE) ending <= 1'b1;
          end
          FUNC_RESET: begin
            phase    <= '0;
            step_now <= '0;
            step_pos <= '0;
            step_len <= '0;
            gain_now <= '0;
            gain_pos <= '0;
            gain_len <= '0;
            ending   <= 1'b0;
            active   <= 1'b1;
          end
          default: begin
          end
        endcase
      end
      if (state == ST_RCHK && ramp_on) begin
        if (ramp_end) begin
          if (sel) begin
            gain_now <= gain_end;
            gain_pos <= '0;
            gain_len <= '0;
          end else begin
            step_now <= step_end;
            step_pos <= '0;
            step_len <= '0;
          end
        end else if (sel) begin
          gain_pos <= pos_n;
        end else begin
          step_pos <= pos_n;
        end
      end
      if (state == ST_RFIN) begin
        if (sel) gain_now <= ramp_res[LEVEL_W-1:0];
        else step_now <= ramp_res;
      end
    end
  end

  // The level product is built one multiplier bit a cycle, low bit first, so
  // that the upper word ends as the product shifted down by eight.
  always_ff @(posedge clk) begin
    if (state == ST_IDLE) begin
      sc_hi <= '0;
    end else if (state == ST_READ) begin
      sc_hi <= '0;
      sc_lo <= gain_now;
      sc_m  <= rd_data;
    end else if (state == ST_SCALE) begin
      sc_hi <= {sc_sum[16], sc_sum[16:1]};
      sc_lo <= {sc_sum[0], sc_lo[LEVEL_W-1:1]};
    end
  end

  // The ramp unit first forms the magnitude of difference times position in
  // hi:lo, then divides it by the length, leaving the quotient in lo.
  always_ff @(posedge clk) begin
    unique case (state)
      ST_RCHK: begin
        hi <= '0;
        lo <= pos_n;
      end
      ST_RMUL: begin
        hi <= {1'b0, mul_sum[16:1]};
        lo <= {mul_sum[0], lo[15:1]};
      end
      ST_RDIV: begin
        hi <= div_ge ? div_t - {1'b0, cur_len} : div_t;
        lo <= {lo[14:0], div_ge};
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == ST_DONE && out_free) begin
      out_valid <= 1'b1;
    end else if (res.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_DONE && out_free) begin
      out_sample   <= sc_hi[SAMPLE_W-1:0];
      out_finished <= ending && gain_now == '0;
    end
  end

endmodule

[tb/wavetable_voice_with_ramps_tb.sv]
`timescale 1ns / 100ps
// Self-checking testbench for the wavetable voice: directed requests, then random request
// mixes under changing back-pressure, checked against an in-bench model of the voice.
// Depends on wvr_pkg, wvr_in_if, wvr_out_if and wavetable_voice_with_ramps.
module wavetable_voice_with_ramps_tb;
  import wvr_pkg::*;

  localparam logic [FUNC_W-1:0] FUNC_SPARE_LO = 3'd6;
  localparam logic [FUNC_W-1:0] FUNC_SPARE_HI = 3'd7;
  localparam int TABLE_DEPTH = 1 << TABLE_AW;
  localparam int RANDOM_PER_PHASE = 475;
  localparam int SETTLE_CYCLES = 200;

  typedef struct packed {
    logic [FUNC_W-1:0]          func;
    logic [15:0]                target;
    logic [RAMP_W-1:0]          ramp_frames;
    logic [TABLE_AW-1:0]        wave_index;
    logic signed [SAMPLE_W-1:0] wave_sample;
  } voice_req_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample;
    logic                       finished;
  } voice_res_t;

  logic clk = 1'b0;
  logic rst;

  wvr_in_if  cmd();
  wvr_out_if res();

  wavetable_voice_with_ramps u_dut (
    .clk (clk),
    .rst (rst),
    .cmd (cmd),
    .res (res)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Model of the voice.
  logic signed [SAMPLE_W-1:0] wave_mem [TABLE_DEPTH];
  bit                         entry_loaded [TABLE_DEPTH];
  logic [PHASE_W-1:0]         phase_acc;
  logic [15:0]                step_cur, step_from, step_to, step_cnt, step_span;
  logic [LEVEL_W-1:0]         lvl_cur, lvl_from, lvl_to;
  logic [RAMP_W-1:0]          lvl_cnt, lvl_span;
  bit                         voice_ending, voice_on;

  voice_res_t results_due [$];
  int send_idle_pct, recv_idle_pct;
  int error_count, n_ticks, n_writes, n_voice_resets, n_terminates, n_finished;

  function automatic longint ramp_point(longint from, longint to, longint cnt, longint span);
    return from + ((to - from) * cnt) / span;
  endfunction

  function automatic logic [TABLE_AW-1:0] table_index();
    return TABLE_AW'(phase_acc >> FRACT_BITS);
  endfunction

  function automatic void aim_level(logic [LEVEL_W-1:0] goal, logic [RAMP_W-1:0] frames);
    lvl_from = lvl_cur;
    lvl_to   = goal;
    lvl_cnt  = '0;
    if (frames != '0 && lvl_from != lvl_to) begin
      lvl_span = frames;
    end else begin
      lvl_cur  = goal;
      lvl_span = '0;
    end
  endfunction

  function automatic bit predict_voice(input voice_req_t r, output voice_res_t o);
    int prod;
    o = '0;
    case (r.func)
      FUNC_TICK: begin
        if (voice_on) begin
          prod = int'(wave_mem[table_index()]) * int'(lvl_cur);
          o.sample = SAMPLE_W'(prod >>> LEVEL_W);
          phase_acc = phase_acc + step_cur;
          if (step_span != '0) begin
            step_cnt = step_cnt + 16'd1;
            if (step_cnt >= step_span) begin
              step_cur  = step_to;
              step_cnt  = '0;
              step_span = '0;
            end else begin
              step_cur = 16'(ramp_point(step_from, step_to, step_cnt, step_span));
            end
          end
          if (lvl_span != '0) begin
            lvl_cnt = lvl_cnt + 16'd1;
            if (lvl_cnt >= lvl_span) begin
              lvl_cur  = lvl_to;
              lvl_cnt  = '0;
              lvl_span = '0;
            end else begin
              lvl_cur = LEVEL_W'(ramp_point(lvl_from, lvl_to, lvl_cnt, lvl_span));
            end
          end
        end
        o.finished = voice_ending && (lvl_cur == '0);
        return 1'b1;
      end
      FUNC_SET_STEP: begin
        step_from = step_cur;
        step_to   = r.target;
        step_cnt  = '0;
        if (r.ramp_frames != '0 && step_from != step_to) begin
          step_span = r.ramp_frames;
        end else begin
          step_cur  = r.target;
          step_span = '0;
        end
      end
      FUNC_SET_LEVEL: aim_level(r.target[LEVEL_W-1:0], r.ramp_frames);
      FUNC_TERMINATE: begin
        aim_level('0, r.ramp_frames);
        voice_ending = 1'b1;
      end
      FUNC_WRITE: begin
        wave_mem[r.wave_index]     = r.wave_sample;
        entry_loaded[r.wave_index] = 1'b1;
      end
      FUNC_RESET: begin
        phase_acc    = '0;
        step_cur     = '0;
        step_cnt     = '0;
        step_span    = '0;
        lvl_cur      = '0;
        lvl_cnt      = '0;
        lvl_span     = '0;
        voice_ending = 1'b0;
        voice_on     = 1'b1;
      end
      default: ;
    endcase
    return 1'b0;
  endfunction

  function automatic voice_req_t make_req(logic [FUNC_W-1:0] func, logic [15:0] target,
                                          logic [RAMP_W-1:0] frames, logic [TABLE_AW-1:0] idx,
                                          logic signed [SAMPLE_W-1:0] smp);
    voice_req_t r;
    r.func        = func;
    r.target      = target;
    r.ramp_frames = frames;
    r.wave_index  = idx;
    r.wave_sample = smp;
    return r;
  endfunction

  task automatic flag_error(string msg);
    if (error_count < 10) $display("[%0t] mismatch: %s", $time, msg);
    error_count++;
  endtask

  task automatic issue(input voice_req_t r);
    voice_res_t e;
    if ($urandom_range(99) < send_idle_pct) begin
      cmd.valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    cmd.valid       <= 1'b1;
    cmd.func        <= r.func;
    cmd.target      <= r.target;
    cmd.ramp_frames <= r.ramp_frames;
    cmd.wave_index  <= r.wave_index;
    cmd.wave_sample <= r.wave_sample;
    do @(posedge clk); while (!cmd.ready);
    case (r.func)
      FUNC_TICK:      n_ticks++;
      FUNC_WRITE:     n_writes++;
      FUNC_RESET:     n_voice_resets++;
      FUNC_TERMINATE: n_terminates++;
      default: ;
    endcase
    if (predict_voice(r, e)) results_due.push_back(e);
  endtask

  // A tick on an active voice must never read a table entry that has not been written,
  // so such an entry is loaded with a random sample just before the tick.
  task automatic send_req(input voice_req_t r);
    if (r.func == FUNC_TICK && voice_on && !entry_loaded[table_index()])
      issue(make_req(FUNC_WRITE, 16'($urandom), 16'($urandom), table_index(),
                     SAMPLE_W'($urandom)));
    issue(r);
  endtask

  task automatic send_tick();
    send_req(make_req(FUNC_TICK, 16'($urandom), 16'($urandom), 8'($urandom), 16'($urandom)));
  endtask

  task automatic drain_results();
    cmd.valid <= 1'b0;
    @(posedge clk);
    while (results_due.size() != 0) @(posedge clk);
  endtask

  function automatic voice_req_t random_req();
    voice_req_t r;
    int pick;
    r = make_req(FUNC_TICK, 16'($urandom), 16'($urandom), 8'($urandom), 16'($urandom));
    case ($urandom_range(9))
      0:       r.ramp_frames = '0;
      1:       r.ramp_frames = 16'($urandom);
      default: r.ramp_frames = 16'($urandom_range(1, 24));
    endcase
    pick = $urandom_range(99);
    if (pick < 52)      r.func = FUNC_TICK;
    else if (pick < 64) r.func = FUNC_SET_STEP;
    else if (pick < 76) r.func = FUNC_SET_LEVEL;
    else if (pick < 80) r.func = FUNC_TERMINATE;
    else if (pick < 92) r.func = FUNC_WRITE;
    else if (pick < 96) r.func = FUNC_RESET;
    else if (pick < 98) r.func = FUNC_SPARE_LO;
    else                r.func = FUNC_SPARE_HI;
    return r;
  endfunction

  task automatic test_inactive_voice();
    send_tick();
    send_req(make_req(FUNC_SPARE_LO, 16'hFFFF, 16'hFFFF, 8'hFF, 16'sh7FFF));
    send_req(make_req(FUNC_SPARE_HI, 16'h0000, 16'h0000, 8'h00, -16'sd32768));
    send_req(make_req(FUNC_SET_STEP, 16'hFFFF, 16'hFFFF, 8'h00, 16'sh0000));
    send_req(make_req(FUNC_TERMINATE, 16'h0000, 16'h0000, 8'h00, 16'sh0000));
    send_tick();
    send_req(make_req(FUNC_WRITE, 16'h0000, 16'h0000, 8'h00, -16'sd32768));
    send_req(make_req(FUNC_WRITE, 16'hFFFF, 16'hFFFF, 8'hFF, 16'sh7FFF));
    send_req(make_req(FUNC_RESET, 16'h0000, 16'h0000, 8'h00, 16'sh0000));
  endtask

  task automatic test_level_scaling();
    send_req(make_req(FUNC_SET_LEVEL, 16'hA5FF, 16'h0000, 8'h00, 16'sh0000));
    send_tick();
    send_req(make_req(FUNC_SET_STEP, 16'hFF00, 16'h0000, 8'h00, 16'sh0000));
    send_tick();
    send_tick();
  endtask

  task automatic test_ramp_rules();
    send_req(make_req(FUNC_SET_LEVEL, 16'hFF00, 16'hFFFF, 8'h00, 16'sh0000));
    send_tick();
    send_req(make_req(FUNC_SET_LEVEL, {8'h5A, lvl_cur}, 16'd7, 8'h00, 16'sh0000));
    send_req(make_req(FUNC_SET_STEP, 16'h0100, 16'd3, 8'h00, 16'sh0000));
    repeat (3) send_tick();
  endtask

  task automatic test_terminate();
    send_req(make_req(FUNC_TERMINATE, 16'h0000, 16'd2, 8'h00, 16'sh0000));
    repeat (3) send_tick();
    send_req(make_req(FUNC_RESET, 16'h0000, 16'h0000, 8'h00, 16'sh0000));
  endtask

  task automatic test_random_mix(int send_pct, int recv_pct);
    drain_results();
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    repeat (RANDOM_PER_PHASE) send_req(random_req());
  endtask

  always @(posedge clk) begin
    res.ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  always @(posedge clk) begin : check_results
    voice_res_t want;
    if (!rst && res.valid && res.ready) begin
      if (res.finished) n_finished++;
      if (results_due.size() == 0) begin
        flag_error($sformatf("unexpected result sample=%0d finished=%0b",
                             res.sample, res.finished));
      end else begin
        want = results_due.pop_front();
        if (res.sample !== want.sample)
          flag_error($sformatf("sample expected %0d got %0d", want.sample, res.sample));
        if (res.finished !== want.finished)
          flag_error($sformatf("finished expected %0b got %0b", want.finished, res.finished));
      end
    end
  end

  initial begin
    #2_000_000;
    $display("Timed out with %0d results outstanding.", results_due.size());
    $display("TB_ERROR");
    $finish;
  end

  initial begin
    rst             = 1'b1;
    cmd.valid       = 1'b0;
    cmd.func        = FUNC_TICK;
    cmd.target      = '0;
    cmd.ramp_frames = '0;
    cmd.wave_index  = '0;
    cmd.wave_sample = '0;
    res.ready       = 1'b0;
    send_idle_pct   = 29;
    recv_idle_pct   = 79;
    error_count     = 0;
    n_ticks         = 0;
    n_writes        = 0;
    n_voice_resets  = 0;
    n_terminates    = 0;
    n_finished      = 0;
    wave_mem        = '{default: '0};
    entry_loaded    = '{default: 1'b0};
    phase_acc       = '0;
    step_cur        = '0;
    step_from       = '0;
    step_to         = '0;
    step_cnt        = '0;
    step_span       = '0;
    lvl_cur         = '0;
    lvl_from        = '0;
    lvl_to          = '0;
    lvl_cnt         = '0;
    lvl_span        = '0;
    voice_ending    = 1'b0;
    voice_on        = 1'b0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    test_inactive_voice();
    test_level_scaling();
    test_ramp_rules();
    test_terminate();
    test_random_mix(29, 79);
    test_random_mix(79, 29);
    test_random_mix(0, 0);

    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (results_due.size() != 0) begin
      $display("%0d expected results never arrived.", results_due.size());
      error_count += results_due.size();
    end
    $display("Run covered %0d ticks, %0d table writes, %0d voice resets and %0d terminations;",
             n_ticks, n_writes, n_voice_resets, n_terminates);
    $display("%0d results showed a finished voice, %0d mismatches in all.",
             n_finished, error_count);
    if (error_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
